// File: rtl/core/pat_pkg.sv
// Shared types and constants for the positional array table.
// Used by pat_cell, pat_chain and positional_array_table_unit; no dependencies.
`timescale 1ns / 1ps

package pat_pkg;

  // Largest supported table depth and the pointer width that covers it (count up to MAX_DEPTH).
  localparam int MAX_DEPTH = 1024;
  localparam int DEPTH_DEF = 64;
  localparam int PTR_W     = $clog2(MAX_DEPTH + 1);

  // Field widths
  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 6;
  localparam int COUNT_W = 7;

  localparam int IN_TDATA_W  = 80;  // 74 payload bits, padded to bytes
  localparam int OUT_TDATA_W = 48;  // 47 payload bits, padded to bytes

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_SEARCH  = 3'd4,
    CMD_DISPLAY = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_ROTATE = 3'd4
  } cell_op_e;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e         op;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] cnt;
  } cell_ctrl_t;

endpackage

// File: rtl/core/pat_cell.sv
// One storage cell of the table chain: holds one entry, loads from a neighbor, the head or the new value.
// Depends on pat_pkg.
`timescale 1ns / 1ps

module pat_cell
  import pat_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] left_i,   // entry of cell IDX-1
  input  logic signed [VAL_W-1:0] right_i,  // entry of cell IDX+1
  input  logic signed [VAL_W-1:0] head_i,   // entry of cell 0 (rotate wrap)
  input  logic signed [VAL_W-1:0] new_i,
  output logic signed [VAL_W-1:0] value_o
);

  localparam logic [PTR_W-1:0] MyIdx   = PTR_W'(IDX);
  localparam logic [PTR_W-1:0] NextIdx = PTR_W'(IDX + 1);

  logic signed [VAL_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      OP_APPEND: begin
        if (MyIdx == ctrl_i.cnt) value_d = new_i;
      end
      OP_INSERT: begin
        if (MyIdx == ctrl_i.pos) begin
          value_d = new_i;
        end else if (MyIdx > ctrl_i.pos && MyIdx <= ctrl_i.cnt) begin
          value_d = left_i;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= ctrl_i.pos && NextIdx < ctrl_i.cnt) value_d = right_i;
      end
      OP_ROTATE: begin
        // live entries move one step toward the head, head wraps to the tail
        if (NextIdx < ctrl_i.cnt) begin
          value_d = right_i;
        end else if (NextIdx == ctrl_i.cnt) begin
          value_d = head_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: rtl/core/pat_chain.sv
// Row of DEPTH table cells linked to their neighbors; exposes the head entry.
// Depends on pat_pkg and pat_cell.
`timescale 1ns / 1ps

module pat_chain
  import pat_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] new_value_i,
  output logic signed [VAL_W-1:0] head_o
);

  logic signed [VAL_W-1:0] vals [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = vals[i+1];
    end

    pat_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (vals[0]),
      .new_i   (new_value_i),
      .value_o (vals[i])
    );
  end

  assign head_o = vals[0];

endmodule

// File: rtl/core/positional_array_table_unit.sv
// Positional array table: controller, result register and the cell chain.
// Depends on pat_pkg and pat_chain.
`timescale 1ns / 1ps

// Packed table of up to DEPTH signed 32-bit entries with a running count.
// Each input item is one command. Clear, append, insert and delete finish in
// the cycle they are accepted: every cell of the chain picks its next entry
// from itself, a neighbor or the new value at once, so these need no walk.
// Search and display walk the table through the head cell: the live entries
// rotate one place per cycle, and after a walk the table is back in its
// original order; on an empty table either gives its status without a walk.
// The walk advances only when the result register is free, so a stalled sink
// stretches both commands. Display gives one result per entry. Search
// compares the head against the key each step and reports the lowest
// matching index at the end. Input is held off while a walk runs and while
// an unread result would be overwritten. Command codes 6 and 7 are taken
// and ignored. Entries come up undefined after reset; no command reads past
// the count, so no clearing pass is needed.
module positional_array_table_unit
  import pat_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF  // 2 .. 64 (6-bit found_index field)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command items
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [2:0] cmd, [9:3] position, [41:10] new_value, [73:42] search_key, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // result items
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] status, [33:2] entry_value, [39:34] found_index, [46:40] count_now,
  // [47] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o  // last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // entry index
  localparam int CW = $clog2(DEPTH + 1);                // entry count
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // ---------------------------------------------------------------- input
  cmd_e                    in_cmd;
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_value;
  logic signed [VAL_W-1:0] in_key;
  logic                    in_acc;

  assign in_cmd   = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign in_pos   = s_axis_tdata_i[CMD_W +: POS_W];
  assign in_value = s_axis_tdata_i[CMD_W+POS_W +: VAL_W];
  assign in_key   = s_axis_tdata_i[CMD_W+POS_W+VAL_W +: VAL_W];

  // ---------------------------------------------------------------- state
  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [IW-1:0]           scan_idx_q, scan_idx_d;
  logic [IW-1:0]           found_q, found_d;
  logic                    hit_q, hit_d;
  logic                    search_q, search_d;   // walk is a search, else display
  logic signed [VAL_W-1:0] key_q, key_d;

  // result register
  logic                    out_valid_q;
  status_e                 res_status_q, res_status_d;
  logic signed [VAL_W-1:0] res_value_q, res_value_d;
  logic [FIDX_W-1:0]       res_idx_q, res_idx_d;
  logic [COUNT_W-1:0]      res_cnt_q;
  logic                    res_last_q, res_last_d;
  logic                    emit;

  logic                    out_free;
  logic [PTR_W-1:0]        pos_ext, cnt_ext;
  logic                    scan_last;
  logic                    head_match;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] head;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_ext    = PTR_W'(in_pos);
  assign cnt_ext    = PTR_W'(cnt_q);
  assign scan_last  = (PTR_W'(scan_idx_q) + PTR_W'(1)) == cnt_ext;
  assign head_match = (head == key_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    scan_idx_d   = scan_idx_q;
    found_d      = found_q;
    hit_d        = hit_q;
    search_d     = search_q;
    key_d        = key_q;
    ctrl.op      = OP_HOLD;
    ctrl.pos     = pos_ext;
    ctrl.cnt     = cnt_ext;
    emit         = 1'b0;
    res_status_d = STAT_OK;
    res_value_d  = '0;
    res_idx_d    = '0;
    res_last_d   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: begin
              emit  = 1'b1;
              cnt_d = '0;
            end
            CMD_APPEND: begin
              emit = 1'b1;
              if (cnt_q == FullCnt) begin
                res_status_d = STAT_BAD;
              end else begin
                ctrl.op = OP_APPEND;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            CMD_INSERT: begin
              emit = 1'b1;
              if (pos_ext > cnt_ext || cnt_q == FullCnt) begin
                res_status_d = STAT_BAD;
              end else begin
                ctrl.op = OP_INSERT;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            CMD_DELETE: begin
              emit = 1'b1;
              if (pos_ext >= cnt_ext) begin
                res_status_d = STAT_BAD;
              end else begin
                ctrl.op = OP_DELETE;
                cnt_d   = cnt_q - CW'(1);
              end
            end
            CMD_SEARCH, CMD_DISPLAY: begin
              if (cnt_q == '0) begin
                emit         = 1'b1;
                res_status_d = (in_cmd == CMD_SEARCH) ? STAT_NOTFOUND : STAT_EMPTY;
              end else begin
                state_d    = ST_SCAN;
                scan_idx_d = '0;
                hit_d      = 1'b0;
                found_d    = '0;
                search_d   = (in_cmd == CMD_SEARCH);
                key_d      = in_key;
              end
            end
            default: ;  // unused codes: no result, no change
          endcase
        end
      end

      ST_SCAN: begin
        if (out_free) begin
          ctrl.op = OP_ROTATE;
          if (search_q) begin
            if (head_match && !hit_q) begin
              hit_d   = 1'b1;
              found_d = scan_idx_q;
            end
            if (scan_last) begin
              emit = 1'b1;
              if (hit_q) begin
                res_idx_d = FIDX_W'(found_q);
              end else if (head_match) begin
                res_idx_d = FIDX_W'(scan_idx_q);
              end else begin
                res_status_d = STAT_NOTFOUND;
              end
            end
          end else begin
            emit        = 1'b1;
            res_value_d = head;
            res_idx_d   = FIDX_W'(scan_idx_q);
            res_last_d  = scan_last;
          end
          if (scan_last) begin
            state_d = ST_IDLE;
          end else begin
            scan_idx_d = scan_idx_q + IW'(1);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      found_q     <= '0;
      hit_q       <= 1'b0;
      search_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_idx_q <= scan_idx_d;
      found_q    <= found_d;
      hit_q      <= hit_d;
      search_q   <= search_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (emit) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_idx_q    <= res_idx_d;
      res_cnt_q    <= COUNT_W'(cnt_d);
      res_last_q   <= res_last_d;
    end
  end

  // ---------------------------------------------------------------- chain
  pat_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .new_value_i (in_value),
    .head_o      (head)
  );

  // ---------------------------------------------------------------- output
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_last_q;
  assign m_axis_tdata_o  = {1'b0, res_cnt_q, res_idx_q, res_value_q, res_status_q};

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (PTR_W'(scan_idx_q) < cnt_ext))
    else $error("walk index past count");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == CMD_APPEND && cnt_q != FullCnt)
      |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("append did not grow the count");

  a_walk_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(cnt_q))
    else $error("count changed during a walk");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !emit)
    else $error("pending result overwritten");

endmodule
